// ----- rtl/core/bnp_pkg.sv -----
// ----------------------------------------------------------------------------
// bnp_pkg
// Shared types and constants of the buzzer note player.
// ----------------------------------------------------------------------------
package bnp_pkg;

    // Longest rest in ticks
    localparam logic [18:0] REST_CAP = 19'd500000;

    // Input action codes
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_LOAD  = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    typedef enum logic [1:0] {
        CMD_NOP   = 2'd0,
        CMD_START = 2'd1,
        CMD_LOAD  = 2'd2,
        CMD_TICK  = 2'd3
    } bnp_kind_t;

    // Classified request, handed from the front end to the execution unit
    typedef struct packed {
        bnp_kind_t   kind;
        logic [18:0] rest_cap;   // rest limited to REST_CAP
        logic        rest_zero;  // tone starts on the load itself
        logic [15:0] period;
        logic [23:0] duration;
        logic        instant;    // zero duration or period below two
        logic [23:0] credit;     // elapsed time credited by an instant finish
        logic [23:0] load_add;   // amount added to the total on the load
    } bnp_cmd_t;

    typedef struct packed {
        logic pin_level;
        logic busy_res;
        logic stopped;
        logic note_finished;
        logic refused;
    } bnp_res_t;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_REST = 4'b0010,
        PH_HIGH = 4'b0100,
        PH_LOW  = 4'b1000
    } bnp_phase_t;

endpackage

// ----- rtl/core/buzzer_note_player_unit.sv -----
// ----------------------------------------------------------------------------
// buzzer_note_player_unit
// Square-wave buzzer note player stepped by one-microsecond tick requests.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake          Direction  Contents
//  -------   -----------------  ---------  --------------------------------------
//  request   push / full        in         action, note_rest, note_period,
//                                          note_duration
//  result    pop / empty        out        pin_level, busy_res, stopped,
//                                          note_finished, refused
//  config    cfg_wr_en          in         cfg_wr_data = max_play_time
//
//  One request per cycle sustained while the result queue has room. A taken
//  request is written into the command queue; the note sequencer then takes it
//  from the queue head, updates its state and writes the result into the
//  result queue.
//  The sequencer only advances when the result queue has room, so a stalled
//  pop holds the sequencer and, once the command queue fills, raises full.
//  Reset clears both queues, idles the sequencer and sets max_play_time to
//  its largest value; the block takes requests straight after reset.
//
module buzzer_note_player_unit
    import bnp_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    // Request queue side
    input  logic        push,
    output logic        full,
    input  logic [1:0]  action,
    input  logic [23:0] note_rest,
    input  logic [15:0] note_period,
    input  logic [23:0] note_duration,
    // Result queue side
    input  logic        pop,
    output logic        empty,
    output logic        pin_level,
    output logic        busy_res,
    output logic        stopped,
    output logic        note_finished,
    output logic        refused,
    // Playback limit register
    input  logic        cfg_wr_en,
    input  logic [30:0] cfg_wr_data
);

    localparam int unsigned CMD_W = $bits(bnp_cmd_t);
    localparam int unsigned RES_W = $bits(bnp_res_t);

    logic             cq_full;
    logic             cq_push;
    bnp_cmd_t         cq_din;
    logic [CMD_W-1:0] cq_dout;
    logic             cq_empty;
    logic             cq_pop;
    logic             rq_full;
    logic             rq_push;
    bnp_res_t         rq_din;
    logic [RES_W-1:0] rq_dout;
    bnp_res_t         res_head;

    // Decode and classify each request
    bnp_front u_front (
        .push          (push),
        .full          (full),
        .action        (action),
        .note_rest     (note_rest),
        .note_period   (note_period),
        .note_duration (note_duration),
        .q_full        (cq_full),
        .q_push        (cq_push),
        .q_cmd         (cq_din)
    );

    // Command queue decouples the front end from the sequencer
    bnp_fifo #(
        .W     (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cq_push),
        .din   (cq_din),
        .full  (cq_full),
        .pop   (cq_pop),
        .dout  (cq_dout),
        .empty (cq_empty)
    );

    // Run the note sequencer and the playback total
    bnp_exec u_exec (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_valid   (!cq_empty),
        .cmd         (bnp_cmd_t'(cq_dout)),
        .cmd_take    (cq_pop),
        .res_full    (rq_full),
        .res_push    (rq_push),
        .res         (rq_din)
    );

    // Result queue holds finished status while the consumer stalls
    bnp_fifo #(
        .W     (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rq_push),
        .din   (rq_din),
        .full  (rq_full),
        .pop   (pop),
        .dout  (rq_dout),
        .empty (empty)
    );

    assign res_head      = bnp_res_t'(rq_dout);
    assign pin_level     = res_head.pin_level;
    assign busy_res      = res_head.busy_res;
    assign stopped       = res_head.stopped;
    assign note_finished = res_head.note_finished;
    assign refused       = res_head.refused;

endmodule

// ----- rtl/core/bnp_fifo.sv -----
// ----------------------------------------------------------------------------
// bnp_fifo
// Small first-in first-out queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module bnp_fifo #(
    parameter int unsigned W     = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] din,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] dout,
    output logic         empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ----- rtl/core/bnp_front.sv -----
// ----------------------------------------------------------------------------
// bnp_front
// Front end: decode the action, cap the rest and precompute load amounts.
// ----------------------------------------------------------------------------
module bnp_front
    import bnp_pkg::*;
(
    input  logic        push,
    output logic        full,
    input  logic [1:0]  action,
    input  logic [23:0] note_rest,
    input  logic [15:0] note_period,
    input  logic [23:0] note_duration,
    input  logic        q_full,
    output logic        q_push,
    output bnp_cmd_t    q_cmd
);

    logic rest_over;
    logic dur_zero;
    logic per_short;

    assign full      = q_full;
    assign q_push    = push;
    assign rest_over = (note_rest > {5'd0, REST_CAP});
    assign dur_zero  = (note_duration == '0);
    assign per_short = (note_period < 16'd2);

    always_comb
    begin
        unique case (action)
            ACT_START: q_cmd.kind = CMD_START;
            ACT_LOAD:  q_cmd.kind = CMD_LOAD;
            ACT_TICK:  q_cmd.kind = CMD_TICK;
            default:   q_cmd.kind = CMD_NOP;
        endcase
        q_cmd.rest_cap  = rest_over ? REST_CAP : note_rest[18:0];
        q_cmd.rest_zero = (note_rest == '0);
        q_cmd.period    = note_period;
        q_cmd.duration  = note_duration;
        q_cmd.instant   = dur_zero || per_short;
        // Credit the whole duration at once for a period below two
        q_cmd.credit    = (!dur_zero && per_short) ? note_duration : '0;
        q_cmd.load_add  = q_cmd.rest_zero ? q_cmd.credit : {5'd0, q_cmd.rest_cap};
    end

endmodule

// ----- rtl/core/bnp_exec.sv -----
// ----------------------------------------------------------------------------
// bnp_exec
// Execution unit: note sequencer, playback total and status result.
// ----------------------------------------------------------------------------
module bnp_exec
    import bnp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [30:0] cfg_wr_data,
    input  logic        cmd_valid,
    input  bnp_cmd_t    cmd,
    output logic        cmd_take,
    input  logic        res_full,
    output logic        res_push,
    output bnp_res_t    res
);

    bnp_phase_t  phase_reg, phase_next;
    logic        stop_reg, stop_next;
    logic [18:0] rest_count_reg, rest_count_next;
    logic [14:0] half_count_reg, half_count_next;
    logic [14:0] half_length_reg, half_length_next;
    logic [15:0] period_reg, period_next;
    logic [23:0] duration_reg, duration_next;
    logic        instant_reg, instant_next;
    logic [23:0] credit_reg, credit_next;
    logic [24:0] elapsed_reg, elapsed_next;
    logic [31:0] total_reg, total_next;
    logic [30:0] max_time_reg;

    logic        load_ok;
    logic        rest_done;
    logic        half_done;
    logic        low_done;
    logic [24:0] elapsed_sum;
    logic [24:0] add_val;
    logic [32:0] sum_raw;
    logic [31:0] total_sat;
    logic        over_limit;
    logic        finished;
    logic        refused;

    assign cmd_take  = cmd_valid && !res_full;
    assign res_push  = cmd_take;

    assign load_ok     = (phase_reg == PH_IDLE) && !stop_reg;
    assign rest_done   = (rest_count_reg <= 19'd1);
    assign half_done   = (half_count_reg <= 15'd1);
    assign elapsed_sum = elapsed_reg + {9'd0, period_reg};
    assign low_done    = (elapsed_sum >= {1'b0, duration_reg});

    // Operand of the one saturating adder on the playback total
    always_comb
    begin
        add_val = '0;
        case (cmd.kind)
            CMD_LOAD:
            begin
                add_val = {1'b0, cmd.load_add};
            end
            CMD_TICK:
            begin
                if (phase_reg == PH_REST)
                begin
                    add_val = {1'b0, credit_reg};
                end
                else if (phase_reg == PH_LOW)
                begin
                    add_val = elapsed_sum;
                end
            end
            default:
            begin
                add_val = '0;
            end
        endcase
    end

    assign sum_raw    = {1'b0, total_reg} + {8'd0, add_val};
    assign total_sat  = sum_raw[32] ? '1 : sum_raw[31:0];
    assign over_limit = (total_sat > {1'b0, max_time_reg});

    always_comb
    begin
        phase_next       = phase_reg;
        stop_next        = stop_reg;
        rest_count_next  = rest_count_reg;
        half_count_next  = half_count_reg;
        half_length_next = half_length_reg;
        period_next      = period_reg;
        duration_next    = duration_reg;
        instant_next     = instant_reg;
        credit_next      = credit_reg;
        elapsed_next     = elapsed_reg;
        total_next       = total_reg;
        finished         = 1'b0;
        refused          = 1'b0;

        case (cmd.kind)
            CMD_START:
            begin
                total_next = '0;
                stop_next  = 1'b0;
            end
            CMD_LOAD:
            begin
                if (!load_ok)
                begin
                    refused = 1'b1;
                end
                else
                begin
                    period_next   = cmd.period;
                    duration_next = cmd.duration;
                    instant_next  = cmd.instant;
                    credit_next   = cmd.credit;
                    elapsed_next  = '0;
                    total_next    = total_sat;
                    if (!cmd.rest_zero)
                    begin
                        rest_count_next = cmd.rest_cap;
                        phase_next      = PH_REST;
                    end
                    else if (cmd.instant)
                    begin
                        finished = 1'b1;
                        stop_next = stop_reg || over_limit;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        half_length_next = cmd.period[15:1];
                        half_count_next  = cmd.period[15:1];
                        phase_next       = PH_HIGH;
                    end
                end
            end
            CMD_TICK:
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        phase_next = PH_IDLE;
                    end
                    PH_REST:
                    begin
                        rest_count_next = rest_count_reg - 1'b1;
                        if (rest_done)
                        begin
                            rest_count_next = '0;
                            elapsed_next    = '0;
                            if (instant_reg)
                            begin
                                total_next = total_sat;
                                stop_next  = stop_reg || over_limit;
                                finished   = 1'b1;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                half_length_next = period_reg[15:1];
                                half_count_next  = period_reg[15:1];
                                phase_next       = PH_HIGH;
                            end
                        end
                    end
                    PH_HIGH:
                    begin
                        half_count_next = half_count_reg - 1'b1;
                        if (half_done)
                        begin
                            half_count_next = half_length_reg;
                            phase_next      = PH_LOW;
                        end
                    end
                    PH_LOW:
                    begin
                        half_count_next = half_count_reg - 1'b1;
                        if (half_done)
                        begin
                            elapsed_next = elapsed_sum;
                            if (low_done)
                            begin
                                total_next = total_sat;
                                stop_next  = stop_reg || over_limit;
                                finished   = 1'b1;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                half_count_next = half_length_reg;
                                phase_next      = PH_HIGH;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_comb
    begin
        res.pin_level     = (phase_next == PH_HIGH);
        res.busy_res      = (phase_next != PH_IDLE);
        res.stopped       = stop_next;
        res.note_finished = finished;
        res.refused       = refused;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            stop_reg        <= 1'b0;
            rest_count_reg  <= '0;
            half_count_reg  <= '0;
            half_length_reg <= '0;
            period_reg      <= '0;
            duration_reg    <= '0;
            instant_reg     <= 1'b0;
            credit_reg      <= '0;
            elapsed_reg     <= '0;
            total_reg       <= '0;
            max_time_reg    <= '1;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_time_reg <= cfg_wr_data;
            end
            if (cmd_take)
            begin
                phase_reg       <= phase_next;
                stop_reg        <= stop_next;
                rest_count_reg  <= rest_count_next;
                half_count_reg  <= half_count_next;
                half_length_reg <= half_length_next;
                period_reg      <= period_next;
                duration_reg    <= duration_next;
                instant_reg     <= instant_next;
                credit_reg      <= credit_next;
                elapsed_reg     <= elapsed_next;
                total_reg       <= total_next;
            end
        end
    end

endmodule

// ----- rtl/core/bnp_checker.sv -----
// ----------------------------------------------------------------------------
// bnp_checker
// Port-level checks of the buzzer note player, bound to the top level.
// ----------------------------------------------------------------------------
module bnp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        pop,
    input logic        empty,
    input logic        pin_level,
    input logic        busy_res,
    input logic        stopped,
    input logic        note_finished,
    input logic        refused
);

    // A waiting result stays until popped
    a_res_held: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty)
        else $error("result dropped without pop");

    // A waiting result keeps its value
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> $stable({pin_level, busy_res, stopped, note_finished, refused}))
        else $error("waiting result changed");

    // High output level only while a note sounds
    a_pin_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && pin_level |-> busy_res)
        else $error("pin high while idle");

    // A finishing note leaves the player idle
    a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && note_finished |-> !busy_res)
        else $error("busy after note finished");

    // A refused load cannot also finish a note
    a_ref_fin: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && refused |-> !note_finished)
        else $error("refused and finished together");

endmodule

bind buzzer_note_player_unit bnp_checker u_bnp_checker (.*);
